FILE: rtl/core/fxlr_pkg.sv
// ----------------------------------------------------------------------------
// fxlr_pkg
// Shared types, codes and sizes for the framed link receiver.
// ----------------------------------------------------------------------------
package fxlr_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int EV_W      = 2;
    localparam int ERR_W     = 16;
    localparam int CFG_IDX_W = 2;

    // default ring size in bytes
    localparam int RING_DEPTH_DEF = 256;

    // input op codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // frame event codes
    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_COMMIT = 2'd1;
    localparam logic [EV_W-1:0] EV_ERROR  = 2'd2;
    localparam logic [EV_W-1:0] EV_DUP    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_OFFSET  = 2'd2;

    // work kind decided by the front end
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_ACK,
        KIND_NOP
    } kind_t;

    // one queued item
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } item_t;

    // configuration settings
    typedef struct packed {
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
        logic [BYTE_W-1:0] length_offset;
    } cfg_t;

endpackage

FILE: rtl/core/fxlr_ram.sv
// ----------------------------------------------------------------------------
// fxlr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fxlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/fxlr_front.sv
// ----------------------------------------------------------------------------
// fxlr_front
// Accepts input items, classifies the op and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fxlr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fxlr_pkg::OP_W-1:0]     op,
    input  logic [fxlr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          q_valid,
    output fxlr_pkg::item_t               q_item,
    input  logic                          q_take
);

    fxlr_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            accept;
    fxlr_pkg::item_t new_item;

    // queue full holds off the sender
    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // op classification
    always_comb
    begin
        new_item.data = rx_byte;
        unique case (op)
            fxlr_pkg::OP_PUSH: new_item.kind = fxlr_pkg::KIND_PUSH;
            fxlr_pkg::OP_POP:  new_item.kind = fxlr_pkg::KIND_POP;
            fxlr_pkg::OP_ACK:  new_item.kind = fxlr_pkg::KIND_ACK;
            fxlr_pkg::OP_NONE: new_item.kind = fxlr_pkg::KIND_NOP;
        endcase
    end

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({accept, q_take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: rtl/core/fxlr_back.sv
// ----------------------------------------------------------------------------
// fxlr_back
// Frame parser, byte ring and counters, with a read stage and output register.
// ----------------------------------------------------------------------------
module fxlr_back #(
    parameter int RING_DEPTH = fxlr_pkg::RING_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fxlr_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  fxlr_pkg::item_t              q_item,
    output logic                         q_take,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fxlr_pkg::EV_W-1:0]    frame_event,
    output logic [fxlr_pkg::BYTE_W-1:0]  read_byte,
    output logic                         read_valid,
    output logic [fxlr_pkg::BYTE_W-1:0]  frames_pending,
    output logic [fxlr_pkg::ERR_W-1:0]   error_total
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_LEN_H = 4'd2,
        PH_LEN_L = 4'd3,
        PH_SEQ   = 4'd4,
        PH_ID_H  = 4'd5,
        PH_ID_L  = 4'd6,
        PH_TS0   = 4'd7,
        PH_TS1   = 4'd8,
        PH_TS2   = 4'd9,
        PH_TS3   = 4'd10,
        PH_DATA  = 4'd11,
        PH_CHECK = 4'd12
    } phase_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // parser and ring state
    phase_t                        phase_reg,     phase_next;
    logic [fxlr_pkg::BYTE_W-1:0]   left_reg,      left_next;
    logic [fxlr_pkg::BYTE_W-1:0]   xor_reg,       xor_next;
    logic [fxlr_pkg::BYTE_W-1:0]   seq_reg,       seq_next;
    logic [fxlr_pkg::BYTE_W-1:0]   prev_seq_reg,  prev_seq_next;
    logic [PTR_W-1:0]              wptr_reg,      wptr_next;
    logic [PTR_W-1:0]              cptr_reg,      cptr_next;
    logic [PTR_W-1:0]              rptr_reg,      rptr_next;
    logic [fxlr_pkg::BYTE_W-1:0]   committed_reg, committed_next;
    logic [fxlr_pkg::BYTE_W-1:0]   handled_reg,   handled_next;
    logic [fxlr_pkg::ERR_W-1:0]    err_reg,       err_next;

    // read stage and output register
    logic                          s1_valid_reg,  s1_valid_next;
    logic [fxlr_pkg::EV_W-1:0]     s1_ev_reg,     s1_ev_next;
    logic                          s1_rv_reg,     s1_rv_next;
    logic [fxlr_pkg::BYTE_W-1:0]   s1_pend_reg,   s1_pend_next;
    logic [fxlr_pkg::ERR_W-1:0]    s1_err_reg,    s1_err_next;
    logic                          out_valid_reg, out_valid_next;
    logic [fxlr_pkg::EV_W-1:0]     out_ev_reg,    out_ev_next;
    logic                          out_rv_reg,    out_rv_next;
    logic [fxlr_pkg::BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic [fxlr_pkg::BYTE_W-1:0]   out_pend_reg,  out_pend_next;
    logic [fxlr_pkg::ERR_W-1:0]    out_err_reg,   out_err_next;

    logic                          exec;
    logic                          s1_adv;
    logic                          ram_we;
    logic [fxlr_pkg::BYTE_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [fxlr_pkg::BYTE_W-1:0]   ram_rdata;
    logic [fxlr_pkg::BYTE_W-1:0]   c;
    logic [fxlr_pkg::EV_W-1:0]     ev;
    logic [fxlr_pkg::BYTE_W-1:0]   len_val;

    // pipeline flow
    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign exec   = q_valid && (!s1_valid_reg || s1_adv);
    assign q_take = exec;
    assign c      = q_item.data;
    assign len_val = c - cfg.length_offset;

    // byte ring
    fxlr_ram #(
        .WIDTH (fxlr_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // item execution
    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        xor_next       = xor_reg;
        seq_next       = seq_reg;
        prev_seq_next  = prev_seq_reg;
        wptr_next      = wptr_reg;
        cptr_next      = cptr_reg;
        rptr_next      = rptr_reg;
        committed_next = committed_reg;
        handled_next   = handled_reg;
        err_next       = err_reg;
        ev             = fxlr_pkg::EV_NONE;
        ram_we         = 1'b0;
        ram_wdata      = c;
        ram_re         = 1'b0;
        s1_rv_next     = 1'b0;

        if (exec)
        begin
            unique case (q_item.kind)
                fxlr_pkg::KIND_PUSH:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (c == cfg.first_sync)
                            begin
                                phase_next = PH_SYNC2;
                            end
                        end
                        PH_SYNC2:
                        begin
                            // second byte match wins over a repeated start byte
                            if (c == cfg.second_sync)
                            begin
                                phase_next = PH_LEN_H;
                            end
                            else if (c != cfg.first_sync)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_LEN_H:
                        begin
                            xor_next   = c;
                            cptr_next  = wptr_reg;
                            phase_next = PH_LEN_L;
                        end
                        PH_LEN_L:
                        begin
                            xor_next   = xor_reg ^ c;
                            left_next  = len_val;
                            ram_we     = 1'b1;
                            ram_wdata  = len_val + 8'd2;
                            wptr_next  = ptr_inc(wptr_reg);
                            phase_next = PH_SEQ;
                        end
                        PH_SEQ:
                        begin
                            seq_next   = c;
                            xor_next   = xor_reg ^ c;
                            phase_next = PH_ID_H;
                        end
                        PH_ID_H, PH_ID_L:
                        begin
                            xor_next   = xor_reg ^ c;
                            ram_we     = 1'b1;
                            wptr_next  = ptr_inc(wptr_reg);
                            phase_next = (phase_reg == PH_ID_H) ? PH_ID_L : PH_TS0;
                        end
                        PH_TS0:
                        begin
                            xor_next   = xor_reg ^ c;
                            phase_next = PH_TS1;
                        end
                        PH_TS1:
                        begin
                            xor_next   = xor_reg ^ c;
                            phase_next = PH_TS2;
                        end
                        PH_TS2:
                        begin
                            xor_next   = xor_reg ^ c;
                            phase_next = PH_TS3;
                        end
                        PH_TS3:
                        begin
                            xor_next   = xor_reg ^ c;
                            phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            xor_next  = xor_reg ^ c;
                            ram_we    = 1'b1;
                            wptr_next = ptr_inc(wptr_reg);
                            // zero length frame stores one byte and drops out
                            if (left_reg != 8'd0)
                            begin
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_CHECK:
                        begin
                            if (c == xor_reg)
                            begin
                                if (prev_seq_reg == seq_reg)
                                begin
                                    wptr_next = cptr_reg;
                                    ev        = fxlr_pkg::EV_DUP;
                                end
                                else
                                begin
                                    prev_seq_next  = seq_reg;
                                    cptr_next      = wptr_reg;
                                    committed_next = committed_reg + 8'd1;
                                    ev             = fxlr_pkg::EV_COMMIT;
                                end
                            end
                            else
                            begin
                                wptr_next = cptr_reg;
                                err_next  = err_reg + 16'd1;
                                ev        = fxlr_pkg::EV_ERROR;
                            end
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            // meaningless phase code
                            phase_next = PH_IDLE;
                            err_next   = err_reg + 16'd1;
                        end
                    endcase
                end
                fxlr_pkg::KIND_POP:
                begin
                    if (rptr_reg != cptr_reg)
                    begin
                        ram_re     = 1'b1;
                        s1_rv_next = 1'b1;
                        rptr_next  = ptr_inc(rptr_reg);
                    end
                end
                fxlr_pkg::KIND_ACK:
                begin
                    if (committed_reg != handled_reg)
                    begin
                        handled_next = handled_reg + 8'd1;
                    end
                end
                fxlr_pkg::KIND_NOP:
                begin
                end
            endcase
        end
    end

    // read stage and output register next values
    always_comb
    begin
        s1_ev_next   = ev;
        s1_pend_next = committed_next - handled_next;
        s1_err_next  = err_next;

        if (exec)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_ev_next   = s1_ev_reg;
        out_rv_next   = s1_rv_reg;
        out_byte_next = s1_rv_reg ? ram_rdata : 8'd0;
        out_pend_next = s1_pend_reg;
        out_err_next  = s1_err_reg;

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            left_reg      <= '0;
            xor_reg       <= '0;
            seq_reg       <= '0;
            prev_seq_reg  <= 8'hFF;
            wptr_reg      <= '0;
            cptr_reg      <= '0;
            rptr_reg      <= '0;
            committed_reg <= '0;
            handled_reg   <= '0;
            err_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ev_reg     <= fxlr_pkg::EV_NONE;
            s1_rv_reg     <= 1'b0;
            s1_pend_reg   <= '0;
            s1_err_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= fxlr_pkg::EV_NONE;
            out_rv_reg    <= 1'b0;
            out_byte_reg  <= '0;
            out_pend_reg  <= '0;
            out_err_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            xor_reg       <= xor_next;
            seq_reg       <= seq_next;
            prev_seq_reg  <= prev_seq_next;
            wptr_reg      <= wptr_next;
            cptr_reg      <= cptr_next;
            rptr_reg      <= rptr_next;
            committed_reg <= committed_next;
            handled_reg   <= handled_next;
            err_reg       <= err_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                s1_ev_reg   <= s1_ev_next;
                s1_rv_reg   <= s1_rv_next;
                s1_pend_reg <= s1_pend_next;
                s1_err_reg  <= s1_err_next;
            end
            if (s1_adv)
            begin
                out_ev_reg   <= out_ev_next;
                out_rv_reg   <= out_rv_next;
                out_byte_reg <= out_byte_next;
                out_pend_reg <= out_pend_next;
                out_err_reg  <= out_err_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_event    = out_ev_reg;
    assign read_valid     = out_rv_reg;
    assign read_byte      = out_byte_reg;
    assign frames_pending = out_pend_reg;
    assign error_total    = out_err_reg;

endmodule

FILE: rtl/core/framed_xor_link_receiver.sv
// ----------------------------------------------------------------------------
// framed_xor_link_receiver
// Sync-byte framed link parser with XOR checksum and a committed-byte ring.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, whatever the op, unless the output stalls;
// a stall fills the input queue and raises in_stall. Each item gives exactly
// one result: it waits in the input queue, the parser step and ring access
// are registered in the read stage, and the ring's registered read data
// joins them in the output register. The ring is a single memory with one
// write and one read port; a push writes it and a pop reads it, so both
// never compete. The ring needs no clearing after reset. Configuration is
// written only while the block is idle; the user, not the block, enforces it.
module framed_xor_link_receiver #(
    parameter int RING_DEPTH = fxlr_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fxlr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fxlr_pkg::BYTE_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fxlr_pkg::OP_W-1:0]       op,
    input  logic [fxlr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fxlr_pkg::EV_W-1:0]       frame_event,
    output logic [fxlr_pkg::BYTE_W-1:0]     read_byte,
    output logic                            read_valid,
    output logic [fxlr_pkg::BYTE_W-1:0]     frames_pending,
    output logic [fxlr_pkg::ERR_W-1:0]      error_total
);

    fxlr_pkg::cfg_t  cfg_reg;
    fxlr_pkg::cfg_t  cfg_next;
    logic            q_valid;
    fxlr_pkg::item_t q_item;
    logic            q_take;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fxlr_pkg::CFG_FIRST_SYNC:  cfg_next.first_sync    = cfg_data;
                fxlr_pkg::CFG_SECOND_SYNC: cfg_next.second_sync   = cfg_data;
                fxlr_pkg::CFG_LEN_OFFSET:  cfg_next.length_offset = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // accept and classify
    fxlr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    // parse, store and report
    fxlr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_take         (q_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_event    (frame_event),
        .read_byte      (read_byte),
        .read_valid     (read_valid),
        .frames_pending (frames_pending),
        .error_total    (error_total)
    );

endmodule

FILE: rtl/core/fxlr_checker.sv
// ----------------------------------------------------------------------------
// fxlr_checker
// Port-level checks for the framed link receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fxlr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [fxlr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [fxlr_pkg::BYTE_W-1:0]     cfg_data,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [fxlr_pkg::OP_W-1:0]       op,
    input logic [fxlr_pkg::BYTE_W-1:0]     rx_byte,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [fxlr_pkg::EV_W-1:0]       frame_event,
    input logic [fxlr_pkg::BYTE_W-1:0]     read_byte,
    input logic                            read_valid,
    input logic [fxlr_pkg::BYTE_W-1:0]     frames_pending,
    input logic [fxlr_pkg::ERR_W-1:0]      error_total
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_event) && $stable(read_byte)
            && $stable(read_valid) && $stable(frames_pending) && $stable(error_total))
        else $error("result payload changed while stalled");

    // a result with no popped byte reports a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_byte == '0)
        else $error("read byte set without a popped byte");

    // a popped byte never comes with a frame event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> frame_event == fxlr_pkg::EV_NONE)
        else $error("frame event on a pop result");

endmodule

bind framed_xor_link_receiver fxlr_checker u_fxlr_checker (.*);

FILE: dv/tb_framed_xor_link_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_xor_link_receiver
// Self-checking bench for the framed link receiver: a short table of directed
// items, then random framed traffic over several sync/offset settings. Every
// item is predicted on acceptance and compared with the block's result.
// ----------------------------------------------------------------------------
module tb_framed_xor_link_receiver;

    import fxlr_pkg::*;

    localparam int RING         = RING_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int N_PHASES     = 6;
    localparam int N_ROWS       = 24;

    // parser phases of the frame hunter
    typedef enum logic [3:0] {
        PH_IDLE, PH_SYNC2, PH_LEN_H, PH_LEN_L, PH_SEQ, PH_ID_H, PH_ID_L,
        PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_DATA, PH_CHECK
    } parse_phase_t;

    // one result of the receiver
    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [BYTE_W-1:0] rd;
        logic              rv;
        logic [BYTE_W-1:0] pend;
        logic [ERR_W-1:0]  err;
    } rx_report_t;

    // one directed item, with its result typed in where typed is set
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [EV_W-1:0]   ev;
        logic [BYTE_W-1:0] rd;
        logic              rv;
        logic [BYTE_W-1:0] pend;
        logic [ERR_W-1:0]  err;
    } directed_row_t;

    // one register setting with its traffic shape
    typedef struct packed {
        logic [BYTE_W-1:0] s1;
        logic [BYTE_W-1:0] s2;
        logic [BYTE_W-1:0] off;
        bit                rand_cfg;
        int                pop_w;
        bit                big;
        int                stall;
        bit                gaps;
        int                budget;
    } link_setting_t;

    localparam link_setting_t SETTINGS_LIST [0:N_PHASES-1] = '{
        '{8'h00, 8'h00, 8'h00, 1'b0, 30, 1'b0, 1, 1'b1, 180},
        '{8'hA5, 8'h5A, 8'h09, 1'b0, 30, 1'b0, 1, 1'b1, 180},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, 30, 1'b0, 2, 1'b0, 180},
        '{8'h7E, 8'h81, 8'h10, 1'b0,  2, 1'b1, 0, 1'b0, 450},
        '{8'h00, 8'h00, 8'h00, 1'b1, 30, 1'b0, 2, 1'b1, 150},
        '{8'h00, 8'hFF, 8'h80, 1'b0, 30, 1'b0, 1, 1'b1, 150}
    };

    // reset config: equal sync bytes of zero, one short frame, drain, acks
    localparam directed_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{OP_POP,  8'h5A, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_ACK,  8'h5A, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_NONE, 8'hFF, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFF, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h01, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFF, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFF, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFF, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'h00, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFF, 1'b0, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_PUSH, 8'hFE, 1'b1, EV_COMMIT, 8'h00, 1'b0, 8'h01, 16'h0000},
        '{OP_POP,  8'h00, 1'b1, EV_NONE,   8'h03, 1'b1, 8'h01, 16'h0000},
        '{OP_POP,  8'hFF, 1'b1, EV_NONE,   8'hFF, 1'b1, 8'h01, 16'h0000},
        '{OP_POP,  8'h00, 1'b1, EV_NONE,   8'h00, 1'b1, 8'h01, 16'h0000},
        '{OP_POP,  8'hFF, 1'b1, EV_NONE,   8'hFF, 1'b1, 8'h01, 16'h0000},
        '{OP_POP,  8'h00, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h01, 16'h0000},
        '{OP_ACK,  8'h00, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_ACK,  8'hFF, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000},
        '{OP_NONE, 8'h00, 1'b1, EV_NONE,   8'h00, 1'b0, 8'h00, 16'h0000}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      op = OP_NONE;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [EV_W-1:0]      frame_event;
    logic [BYTE_W-1:0]    read_byte;
    logic                 read_valid;
    logic [BYTE_W-1:0]    frames_pending;
    logic [ERR_W-1:0]     error_total;

    // predicted receiver state
    parse_phase_t      p_phase = PH_IDLE;
    logic [BYTE_W-1:0] p_left = '0;
    logic [BYTE_W-1:0] p_xor = '0;
    logic [BYTE_W-1:0] p_seq = '0;
    logic [BYTE_W-1:0] p_prev_seq = 8'hFF;
    logic [BYTE_W-1:0] ring_copy [RING];
    int                wr_ptr = 0;
    int                commit_ptr = 0;
    int                rd_ptr = 0;
    logic [BYTE_W-1:0] frames_done = '0;
    logic [BYTE_W-1:0] frames_acked = '0;
    logic [ERR_W-1:0]  err_count = '0;
    logic [BYTE_W-1:0] cfg_first = '0;
    logic [BYTE_W-1:0] cfg_second = '0;
    logic [BYTE_W-1:0] cfg_offset = '0;

    rx_report_t        reports_due [$];
    logic              row_typed = 1'b0;
    rx_report_t        row_report = '0;
    int                mismatches = 0;
    int                cycles = 0;
    int                accepted = 0;
    int                sent_items = 0;
    int                n_commit = 0;
    int                n_bad_sum = 0;
    int                n_dup = 0;
    int                n_popped = 0;
    int                burst_left = 0;
    bit                gap_mode = 1'b0;
    int                stall_mode = 0;
    logic [12:0]       stall_pattern = 13'b1_0110_0011_1000;

    framed_xor_link_receiver #(
        .RING_DEPTH(RING)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_event   (frame_event),
        .read_byte     (read_byte),
        .read_valid    (read_valid),
        .frames_pending(frames_pending),
        .error_total   (error_total)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("run stopped: no progress after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver backpressure: rotating pattern or random, per setting
    always @(negedge clk)
    begin
        stall_pattern <= {stall_pattern[0], stall_pattern[12:1]};
        case (stall_mode)
            1: out_stall <= stall_pattern[0];
            2: out_stall <= ($urandom_range(0, 99) < 45);
            default: out_stall <= 1'b0;
        endcase
    end

    function automatic void ring_store(input logic [BYTE_W-1:0] b);
        ring_copy[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % RING;
    endfunction

    // receiver response to one item, advancing the predicted state
    task automatic link_step(input logic [OP_W-1:0] o, input logic [BYTE_W-1:0] c,
                             output rx_report_t r);
        r = '0;
        case (o)
            OP_PUSH:
            begin
                case (p_phase)
                    PH_IDLE:
                        if (c == cfg_first) p_phase = PH_SYNC2;
                    PH_SYNC2:
                    begin
                        // second byte wins when both sync values are equal
                        if (c == cfg_second) p_phase = PH_LEN_H;
                        else if (c == cfg_first) p_phase = PH_SYNC2;
                        else p_phase = PH_IDLE;
                    end
                    PH_LEN_H:
                    begin
                        // high length byte seeds the checksum, marks the commit point
                        p_xor = c;
                        commit_ptr = wr_ptr;
                        p_phase = PH_LEN_L;
                    end
                    PH_LEN_L:
                    begin
                        p_xor = p_xor ^ c;
                        p_left = c - cfg_offset;
                        ring_store(p_left + 8'd2);
                        p_phase = PH_SEQ;
                    end
                    PH_SEQ:
                    begin
                        p_seq = c;
                        p_xor = p_xor ^ c;
                        p_phase = PH_ID_H;
                    end
                    PH_ID_H, PH_ID_L:
                    begin
                        p_xor = p_xor ^ c;
                        ring_store(c);
                        p_phase = parse_phase_t'(p_phase + 1);
                    end
                    PH_TS0, PH_TS1, PH_TS2, PH_TS3:
                    begin
                        p_xor = p_xor ^ c;
                        p_phase = parse_phase_t'(p_phase + 1);
                    end
                    PH_DATA:
                    begin
                        ring_store(c);
                        p_xor = p_xor ^ c;
                        // zero length: one byte stored, back to idle, nothing committed
                        if (p_left != 0)
                        begin
                            p_left = p_left - 8'd1;
                            if (p_left == 0) p_phase = PH_CHECK;
                        end
                        else
                        begin
                            p_phase = PH_IDLE;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (c == p_xor)
                        begin
                            if (p_prev_seq == p_seq)
                            begin
                                wr_ptr = commit_ptr;
                                r.ev = EV_DUP;
                            end
                            else
                            begin
                                p_prev_seq = p_seq;
                                commit_ptr = wr_ptr;
                                frames_done = frames_done + 8'd1;
                                r.ev = EV_COMMIT;
                            end
                        end
                        else
                        begin
                            wr_ptr = commit_ptr;
                            err_count = err_count + 16'd1;
                            r.ev = EV_ERROR;
                        end
                        p_phase = PH_IDLE;
                    end
                    default:
                    begin
                        p_phase = PH_IDLE;
                        err_count = err_count + 16'd1;
                    end
                endcase
            end
            OP_POP:
            begin
                if (rd_ptr != commit_ptr)
                begin
                    r.rd = ring_copy[rd_ptr];
                    r.rv = 1'b1;
                    rd_ptr = (rd_ptr + 1) % RING;
                end
            end
            OP_ACK:
            begin
                if (frames_done != frames_acked) frames_acked = frames_acked + 8'd1;
            end
            default:
            begin
            end
        endcase
        r.pend = frames_done - frames_acked;
        r.err = err_count;
    endtask

    // result check and prediction of each accepted item
    always @(posedge clk)
    begin : monitor
        rx_report_t got_exp;
        rx_report_t r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result with no item waiting: ev=%0d rd=%02h rv=%0d",
                                 $realtime, frame_event, read_byte, read_valid);
                end
                else
                begin
                    got_exp = reports_due.pop_front();
                    if (got_exp.ev !== frame_event || got_exp.rd !== read_byte ||
                        got_exp.rv !== read_valid || got_exp.pend !== frames_pending ||
                        got_exp.err !== error_total)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp ev=%0d rd=%02h rv=%0d pend=%0d err=%0d",
                                     $realtime, got_exp.ev, got_exp.rd, got_exp.rv,
                                     got_exp.pend, got_exp.err);
                            $display("%0t: mismatch got ev=%0d rd=%02h rv=%0d pend=%0d err=%0d",
                                     $realtime, frame_event, read_byte, read_valid,
                                     frames_pending, error_total);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                link_step(op, rx_byte, r);
                accepted = accepted + 1;
                if (r.ev == EV_COMMIT) n_commit = n_commit + 1;
                if (r.ev == EV_ERROR) n_bad_sum = n_bad_sum + 1;
                if (r.ev == EV_DUP) n_dup = n_dup + 1;
                if (r.rv) n_popped = n_popped + 1;
                reports_due.push_back(row_typed ? row_report : r);
            end
        end
    end

    // drive one item in sender bursts and wait for it to be taken
    task automatic send_item(input logic [OP_W-1:0] o, input logic [BYTE_W-1:0] b,
                             input logic typed, input rx_report_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gap_mode ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        op = o;
        rx_byte = b;
        row_typed = typed;
        row_report = want;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (o != OP_NONE) sent_items = sent_items + 1;
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        send_item(OP_PUSH, b, 1'b0, '0);
    endtask

    // push filler bytes that match no sync value until the parser is idle
    task automatic settle_parser();
        logic [BYTE_W-1:0] fill;
        while (p_phase != PH_IDLE)
        begin
            fill = 8'($urandom_range(0, 255));
            while (fill == cfg_first || fill == cfg_second) fill = fill + 8'd1;
            push_byte(fill);
        end
    endtask

    // one frame with random content, cut short when cut is nonzero
    task automatic send_frame(input int n, input bit bad_sum, input bit repeat_seq,
                              input int cut);
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] seq_b;
        int                total;
        seq_b = repeat_seq ? p_prev_seq : 8'($urandom_range(0, 255));
        if (!repeat_seq && seq_b == p_prev_seq) seq_b = seq_b + 8'd1;
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'(n) + cfg_offset);
        body.push_back(seq_b);
        // id and timestamp
        repeat (6) body.push_back(8'($urandom_range(0, 255)));
        if (n == 0)
            body.push_back(8'($urandom_range(0, 255)));
        else
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        foreach (body[i]) sum = sum ^ body[i];
        if (n > 0) body.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
        total = body.size() + 2;
        if (cut > 0 && cut < total) total = cut;
        for (int i = 0; i < total; i++)
            push_byte(i == 0 ? cfg_first : (i == 1 ? cfg_second : body[i-2]));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge clk);
        case (idx)
            CFG_FIRST_SYNC:  cfg_first = v;
            CFG_SECOND_SYNC: cfg_second = v;
            CFG_LEN_OFFSET:  cfg_offset = v;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // stop sending and let every expected result come back
    task automatic drain();
        in_valid = 1'b0;
        while (reports_due.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        int                start_cnt;
        int                pick;
        int                n;
        int                k;
        link_setting_t     ls;
        directed_row_t     row;
        logic [BYTE_W-1:0] b;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int p = 0; p < N_PHASES; p++)
        begin
            ls = SETTINGS_LIST[p];
            if (p > 0)
            begin
                drain();
                write_reg(CFG_FIRST_SYNC, ls.rand_cfg ? 8'($urandom_range(0, 255)) : ls.s1);
                write_reg(CFG_SECOND_SYNC, ls.rand_cfg ? 8'($urandom_range(0, 255)) : ls.s2);
                write_reg(CFG_LEN_OFFSET, ls.rand_cfg ? 8'($urandom_range(0, 255)) : ls.off);
            end
            stall_mode = ls.stall;
            gap_mode = ls.gaps;
            if (p == 0)
            begin
                foreach (DIRECTED_ROWS[i])
                begin
                    row = DIRECTED_ROWS[i];
                    send_item(row.op, row.data, row.typed,
                              rx_report_t'({row.ev, row.rd, row.rv, row.pend, row.err}));
                end
            end
            // random traffic: mostly whole frames, some pops, acks and noise
            start_cnt = sent_items;
            while (sent_items - start_cnt < ls.budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    if ($urandom_range(0, 9) != 0) settle_parser();
                    k = $urandom_range(0, 99);
                    if (k < 5) n = 0;
                    else if (k < 72) n = ls.big ? $urandom_range(20, 60) : $urandom_range(1, 8);
                    else if (k < 97) n = $urandom_range(9, 40);
                    else n = $urandom_range(200, 255);
                    send_frame(n, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12, 0);
                end
                else if (pick < 50 + ls.pop_w)
                begin
                    k = (commit_ptr - rd_ptr + RING) % RING + 2;
                    if (k > 20) k = 20;
                    repeat ($urandom_range(1, k))
                        send_item(OP_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                else
                begin
                    k = $urandom_range(0, 9);
                    if (k < 3)
                    begin
                        repeat ($urandom_range(1, 3))
                            send_item(OP_ACK, 8'($urandom_range(0, 255)), 1'b0, '0);
                    end
                    else if (k < 6)
                    begin
                        // stray bytes, sync values among them
                        repeat ($urandom_range(1, 5))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if ($urandom_range(0, 9) < 3) b = $urandom_range(0, 1) ? cfg_first
                                                                                   : cfg_second;
                            push_byte(b);
                        end
                    end
                    else if (k < 9)
                    begin
                        n = $urandom_range(1, 8);
                        send_frame(n, 1'b0, 1'b0, $urandom_range(1, n + 11));
                    end
                    else
                    begin
                        send_item(OP_NONE, 8'($urandom_range(0, 255)), 1'b0, '0);
                    end
                end
            end
        end
        drain();
        repeat (10) @(negedge clk);
        $display("covered %0d items over %0d register settings: %0d frames committed,",
                 accepted, N_PHASES, n_commit);
        $display("%0d checksum rollbacks, %0d repeated sequences dropped, %0d bytes popped",
                 n_bad_sum, n_dup, n_popped);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fxlr_pkg.sv
rtl/core/fxlr_ram.sv
rtl/core/fxlr_front.sv
rtl/core/fxlr_back.sv
rtl/core/framed_xor_link_receiver.sv
rtl/core/fxlr_checker.sv
dv/tb_framed_xor_link_receiver.sv
